// ----- rtl/argument_splitter_macros.svh -----
// Assertion macros used by the argument splitter checker.
// Expects clk and arst_n in the scope of every use.
`ifndef ARGUMENT_SPLITTER_MACROS_SVH
`define ARGUMENT_SPLITTER_MACROS_SVH

// same-cycle implication
`define ASP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("argument_splitter check failed");

// next-cycle implication
`define ASP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("argument_splitter check failed");

`endif

// ----- rtl/asp_pkg.sv -----
// Package for the argument splitter: word types, byte codes, sizes, whitespace test.
// No dependencies.
package asp_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam int REPORT_WIDTH    = 16;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam logic KIND_CHAR    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic                    kind;
		logic [7:0]              out_char;
		logic                    new_arg;
		logic [REPORT_WIDTH-1:0] arg_count;
		logic [REPORT_WIDTH-1:0] char_count;
		logic                    malformed;
	} result_t;

	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} push_t;

	function automatic logic is_white(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

// ----- rtl/argument_splitter.sv -----
// Argument splitter top level: one byte word in, character and summary words out.
// From input accept to first result word: input register, then result queue.
// Throughput: one input word per cycle while the queue has room; a byte with two
// results (kept char and summary) leaves two words; the queue gives one per cycle.
// Reset: clears parser state to a fresh string, max_length to 0, queue empty.
// Depends on asp_pkg, asp_core, asp_queue.
module argument_splitter #(
	parameter int COUNT_WIDTH = asp_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  out_char,
	output logic        new_arg,
	output logic [15:0] arg_count,
	output logic [15:0] char_count,
	output logic        malformed
);
	asp_pkg::push_t   push;
	asp_pkg::result_t word;
	logic             room;

	asp_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.ch         (ch),
		.last       (last),
		.room       (room),
		.push       (push)
	);

	asp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (word)
	);

	assign kind       = word.kind;
	assign out_char   = word.out_char;
	assign new_arg    = word.new_arg;
	assign arg_count  = word.arg_count;
	assign char_count = word.char_count;
	assign malformed  = word.malformed;

endmodule

// ----- rtl/asp_queue.sv -----
// Result queue of the argument splitter: takes up to two words per cycle,
// gives one per cycle. Depends on asp_pkg.
module asp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  asp_pkg::push_t  push,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output asp_pkg::result_t out_word
);
	localparam int DEPTH = asp_pkg::QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	asp_pkg::result_t     mem_q [DEPTH];
	logic [AW-1:0]        wp_q;
	logic [AW-1:0]        rp_q;
	logic [CW-1:0]        cnt_q;
	logic                 pop;
	logic [CW-1:0]        n_push;
	logic [AW-1:0]        wp_1;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_word  = mem_q[rp_q];
	assign room      = (cnt_q <= CW'(DEPTH - 2));
	assign n_push    = CW'(push.v0) + CW'(push.v1);
	assign wp_1      = wp_q + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + AW'(n_push);
			if (pop) begin
				rp_q <= rp_q + AW'(1);
			end
			cnt_q <= cnt_q + n_push - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wp_1] <= push.r1;
		end
	end

endmodule

// ----- rtl/asp_core.sv -----
// Parser of the argument splitter: input register, quote/escape state and
// counters, result words toward the queue. Depends on asp_pkg.
module asp_core #(
	parameter int COUNT_WIDTH = asp_pkg::COUNT_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [15:0]    cfg_wr_data,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     ch,
	input  logic           last,
	input  logic           room,
	output asp_pkg::push_t push
);
	localparam int RW = asp_pkg::REPORT_WIDTH;
	localparam int XW = (COUNT_WIDTH > RW) ? COUNT_WIDTH : RW;

	logic                   v_s1;
	logic [7:0]             ch_s1;
	logic                   last_s1;
	logic [15:0]            max_len_q;
	logic                   quote_q, esc_q, bnd_q, drain_q;
	logic [15:0]            pos_q;
	logic [COUNT_WIDTH-1:0] args_q, chars_q;

	logic                   consume;
	logic                   kept, ended;
	logic                   quote_n, esc_n, bnd_n;
	logic [15:0]            pos_n;
	logic [COUNT_WIDTH-1:0] args_n, chars_n;
	logic [XW-1:0]          args_x, chars_x;
	asp_pkg::result_t       char_w, sum_w;

	assign consume  = v_s1 && room;
	assign in_ready = !v_s1 || room;

	always_comb begin
		kept    = 1'b0;
		ended   = 1'b0;
		quote_n = quote_q;
		esc_n   = esc_q;
		bnd_n   = bnd_q;
		args_n  = args_q;
		chars_n = chars_q;
		if (esc_q) begin
			esc_n = 1'b0;
			if (ch_s1 == asp_pkg::CH_NUL) begin
				esc_n = 1'b1;
				ended = 1'b1;
			end else begin
				kept = 1'b1;
			end
		end else if (ch_s1 == asp_pkg::CH_NUL) begin
			ended = 1'b1;
		end else if (ch_s1 == asp_pkg::CH_BSLASH) begin
			esc_n = 1'b1;
		end else if (ch_s1 == asp_pkg::CH_QUOTE) begin
			quote_n = !quote_q;
			bnd_n   = 1'b1;
		end else if (!quote_q && asp_pkg::is_white(ch_s1)) begin
			bnd_n = 1'b1;
		end else begin
			kept = 1'b1;
		end
		if (kept) begin
			bnd_n = 1'b0;
			if (bnd_q && (args_q != '1)) begin
				args_n = args_q + COUNT_WIDTH'(1);
			end
			if (chars_q != '1) begin
				chars_n = chars_q + COUNT_WIDTH'(1);
			end
		end
		pos_n = (pos_q != 16'hFFFF) ? pos_q + 16'd1 : pos_q;
		if ((max_len_q != 16'd0) && (pos_n >= max_len_q)) begin
			ended = 1'b1;
		end
		if (last_s1) begin
			ended = 1'b1;
		end
	end

	assign args_x  = XW'(args_n);
	assign chars_x = XW'(chars_n);

	always_comb begin
		char_w            = '0;
		char_w.kind       = asp_pkg::KIND_CHAR;
		char_w.out_char   = ch_s1;
		char_w.new_arg    = bnd_q;
		sum_w             = '0;
		sum_w.kind        = asp_pkg::KIND_SUMMARY;
		sum_w.arg_count   = (args_x > XW'(16'hFFFF)) ? 16'hFFFF : args_x[RW-1:0];
		sum_w.char_count  = (chars_x > XW'(16'hFFFF)) ? 16'hFFFF : chars_x[RW-1:0];
		sum_w.malformed   = quote_n || esc_n;
		push.v0 = consume && !drain_q && (kept || ended);
		push.v1 = consume && !drain_q && kept && ended;
		push.r0 = kept ? char_w : sum_w;
		push.r1 = sum_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			max_len_q <= '0;
			quote_q   <= 1'b0;
			esc_q     <= 1'b0;
			bnd_q     <= 1'b1;
			drain_q   <= 1'b0;
			pos_q     <= '0;
			args_q    <= '0;
			chars_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				max_len_q <= cfg_wr_data;
			end
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (consume) begin
				if (last_s1) begin
					quote_q <= 1'b0;
					esc_q   <= 1'b0;
					bnd_q   <= 1'b1;
					drain_q <= 1'b0;
					pos_q   <= '0;
					args_q  <= '0;
					chars_q <= '0;
				end else if (!drain_q) begin
					quote_q <= quote_n;
					esc_q   <= esc_n;
					bnd_q   <= bnd_n;
					drain_q <= ended;
					pos_q   <= pos_n;
					args_q  <= args_n;
					chars_q <= chars_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

endmodule

// ----- rtl/asp_checker.sv -----
// Port-level checks for the argument splitter, bound to the top level.
// Depends on argument_splitter_macros.svh and asp_pkg.
`include "argument_splitter_macros.svh"

module asp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [7:0]  out_char,
	input logic        new_arg,
	input logic [15:0] arg_count,
	input logic [15:0] char_count,
	input logic        malformed
);

	`ASP_ASSERT_NOW(a_sum_no_char, out_valid && (kind == asp_pkg::KIND_SUMMARY), (out_char == 8'd0) && !new_arg)
	`ASP_ASSERT_NOW(a_char_no_sum, out_valid && (kind == asp_pkg::KIND_CHAR), (arg_count == 16'd0) && (char_count == 16'd0) && !malformed)
	`ASP_ASSERT_NOW(a_char_nonzero, out_valid && (kind == asp_pkg::KIND_CHAR), out_char != asp_pkg::CH_NUL)
	`ASP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

endmodule

bind argument_splitter asp_checker u_asp_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for argument_splitter: feeds byte words with random stalls on both
// sides and checks each result word against a tokenizer prediction kept here.
// Depends on asp_pkg and the argument_splitter RTL.

class token_scoreboard;
	asp_pkg::result_t tokens_due[$];
	logic [15:0]      limit;
	logic             in_quote, escape_wait, boundary_wait, draining;
	logic [15:0]      position, args_seen, chars_kept;
	int               words_seen, tokens_checked, strings_ended, fails;

	function new();
		limit = 16'd0;
		words_seen = 0;
		tokens_checked = 0;
		strings_ended = 0;
		fails = 0;
		restart();
	endfunction

	function void restart();
		in_quote = 1'b0;
		escape_wait = 1'b0;
		boundary_wait = 1'b1;
		draining = 1'b0;
		position = 16'd0;
		args_seen = 16'd0;
		chars_kept = 16'd0;
	endfunction

	function void push_token(logic k, logic [7:0] c, logic na, logic [15:0] ac,
				logic [15:0] cc, logic mf);
		asp_pkg::result_t r;
		r.kind = k;
		r.out_char = c;
		r.new_arg = na;
		r.arg_count = ac;
		r.char_count = cc;
		r.malformed = mf;
		tokens_due.push_back(r);
	endfunction

	function void split_byte(logic [7:0] c, logic is_last);
		logic ended, keep;
		ended = 1'b0;
		keep = 1'b0;
		words_seen++;
		if (draining) begin
			if (is_last)
				restart();
			return;
		end
		if (escape_wait) begin
			escape_wait = 1'b0;
			if (c == asp_pkg::CH_NUL) begin
				escape_wait = 1'b1;
				ended = 1'b1;
			end else
				keep = 1'b1;
		end else if (c == asp_pkg::CH_NUL)
			ended = 1'b1;
		else if (c == asp_pkg::CH_BSLASH)
			escape_wait = 1'b1;
		else if (c == asp_pkg::CH_QUOTE) begin
			in_quote = !in_quote;
			boundary_wait = 1'b1;
		end else if (!in_quote && (c == asp_pkg::CH_SPACE ||
				(c >= asp_pkg::CH_TAB && c <= asp_pkg::CH_CR)))
			boundary_wait = 1'b1;
		else
			keep = 1'b1;

		if (keep) begin
			push_token(asp_pkg::KIND_CHAR, c, boundary_wait, 16'd0, 16'd0, 1'b0);
			if (boundary_wait && args_seen != 16'hFFFF)
				args_seen++;
			if (chars_kept != 16'hFFFF)
				chars_kept++;
			boundary_wait = 1'b0;
		end
		if (position != 16'hFFFF)
			position++;
		if (limit != 16'd0 && position >= limit)
			ended = 1'b1;
		if (is_last)
			ended = 1'b1;
		if (ended) begin
			push_token(asp_pkg::KIND_SUMMARY, 8'h00, 1'b0, args_seen, chars_kept,
				in_quote || escape_wait);
			if (is_last)
				restart();
			else
				draining = 1'b1;
		end
	endfunction

	function void compare(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fails++;
		end
	endfunction

	function void check_token(asp_pkg::result_t got);
		asp_pkg::result_t want;
		tokens_checked++;
		if (tokens_due.size() == 0) begin
			$display("%0t: result word, expected none, actual %h", $time, got);
			fails++;
			return;
		end
		want = tokens_due.pop_front();
		if (want.kind == asp_pkg::KIND_SUMMARY)
			strings_ended++;
		compare("kind", want.kind, got.kind);
		compare("out_char", want.out_char, got.out_char);
		compare("new_arg", want.new_arg, got.new_arg);
		compare("arg_count", want.arg_count, got.arg_count);
		compare("char_count", want.char_count, got.char_count);
		compare("malformed", want.malformed, got.malformed);
	endfunction
endclass

module tb_top;

	logic        clk, arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid, in_ready;
	logic [7:0]  ch;
	logic        last;
	logic        out_valid, out_ready;
	logic        kind;
	logic [7:0]  out_char;
	logic        new_arg;
	logic [15:0] arg_count, char_count;
	logic        malformed;
	logic        idle_on;

	token_scoreboard sb = new();

	argument_splitter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.ch         (ch),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.out_char   (out_char),
		.new_arg    (new_arg),
		.arg_count  (arg_count),
		.char_count (char_count),
		.malformed  (malformed)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_token({kind, out_char, new_arg, arg_count, char_count, malformed});
	end

	initial begin
		out_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("%0t: watchdog expired", $time);
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_word(input logic [7:0] c, input logic is_last);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		last <= is_last;
		do @(posedge clk); while (!in_ready);
		sb.split_byte(c, is_last);
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (sb.tokens_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_limit(input logic [15:0] v);
		hold_until_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.limit = v;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 8'($urandom_range(8'h61, 8'h7A));
			4: return 8'($urandom_range(8'h30, 8'h39));
			5: return asp_pkg::CH_SPACE;
			6: return 8'($urandom_range(asp_pkg::CH_TAB, asp_pkg::CH_CR));
			7: return asp_pkg::CH_QUOTE;
			8: return asp_pkg::CH_BSLASH;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	// end by last flag, by a zero byte and trailing junk, or run on as noise
	task automatic send_string(input int len);
		int tail;
		tail = $urandom_range(0, 9);
		for (int i = 0; i < len; i++)
			send_word(pick_byte(), (tail < 5) && (i == len - 1));
		if (tail >= 5 && tail < 8) begin
			send_word(asp_pkg::CH_NUL, 1'b0);
			repeat ($urandom_range(0, 3)) send_word(8'($urandom), 1'b0);
			send_word(8'($urandom), 1'b1);
		end else if (tail >= 8)
			send_word(8'($urandom), 1'($urandom_range(0, 1)));
	endtask

	task automatic run_phase(input logic [15:0] lim, input int count);
		int start;
		set_limit(lim);
		start = sb.words_seen;
		while (sb.words_seen - start < count) begin
			if ($urandom_range(0, 7) == 0)
				send_string($urandom_range(13, 40));
			else
				send_string($urandom_range(1, 12));
			if (lim == 16'd0 && sb.words_seen - start >= count / 2 &&
					sb.words_seen - start < count / 2 + 12)
				hold_until_drained();
		end
	endtask

	initial begin
		in_valid = 1'b0;
		ch = 8'h00;
		last = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 16'd0;
		idle_on = 1'b1;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// quoting, whitespace, escaped quote and escaped space, then last
		send_word(8'h61, 1'b0);
		send_word(asp_pkg::CH_TAB, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(asp_pkg::CH_QUOTE, 1'b0);
		send_word(asp_pkg::CH_SPACE, 1'b0);
		send_word(asp_pkg::CH_QUOTE, 1'b0);
		send_word(asp_pkg::CH_BSLASH, 1'b0);
		send_word(asp_pkg::CH_QUOTE, 1'b0);
		send_word(asp_pkg::CH_BSLASH, 1'b0);
		send_word(asp_pkg::CH_SPACE, 1'b0);
		send_word(8'h01, 1'b1);
		// open quote ended by zero, then drop bytes until last
		send_word(asp_pkg::CH_QUOTE, 1'b0);
		send_word(8'h78, 1'b0);
		send_word(asp_pkg::CH_NUL, 1'b0);
		send_word(8'h79, 1'b0);
		send_word(asp_pkg::CH_NUL, 1'b1);
		// escaped zero, dangling backslash on last, empty string
		send_word(asp_pkg::CH_BSLASH, 1'b0);
		send_word(asp_pkg::CH_NUL, 1'b0);
		send_word(asp_pkg::CH_CR, 1'b1);
		send_word(asp_pkg::CH_BSLASH, 1'b1);
		send_word(asp_pkg::CH_NUL, 1'b1);

		// escaped byte lands exactly on the limit
		set_limit(16'd2);
		send_word(asp_pkg::CH_BSLASH, 1'b0);
		send_word(8'h41, 1'b0);
		send_word(8'h42, 1'b0);
		send_word(8'h43, 1'b1);

		run_phase(16'd1, 150);
		run_phase(16'hFFFF, 150);
		run_phase(16'($urandom_range(2, 12)), 150);
		run_phase(16'd0, 150);
		run_phase(16'($urandom_range(3, 30)), 150);
		run_phase(16'($urandom_range(1, 8)), 150);
		run_phase(16'd0, 150);

		idle_on = 1'b0;
		run_phase(16'($urandom_range(4, 20)), 100);

		in_valid <= 1'b0;
		while (sb.tokens_due.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		$display("Sent %0d byte words, checked %0d result words over %0d strings,",
			sb.words_seen, sb.tokens_checked, sb.strings_ended);
		$display("with limits from 0 to 65535, quotes, escapes, zero bytes and drops.");
		if (sb.fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
